@@ hdl/lir_pkg.sv @@
`default_nettype none

package lir_pkg;

  // Field and register widths.
  localparam int SAMPLE_W  = 24;
  localparam int FRAC_BITS = 16;
  localparam int COUNT_W   = 24;
  localparam int STEP_W    = 21;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Position relative to the previous sample; holds up to one plus the largest step.
  localparam int REL_W  = STEP_W + 1;
  // Sample difference, one bit wider than a sample.
  localparam int DIFF_W = SAMPLE_W + 1;
  // Output count limit (count << FRAC_BITS) and running product (index + 1) * step.
  localparam int CAP_W  = COUNT_W + FRAC_BITS;
  localparam int LIM_W  = COUNT_W + 1 + STEP_W;

  // Bit-serial multiplier: signed multiplicand, unsigned multiplier one bit a cycle.
  localparam int MUL_A_W   = COUNT_W + 2;
  localparam int MUL_B_W   = STEP_W;
  localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam logic [REL_W-1:0]  ONE_POS  = REL_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 5);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1) << FRAC_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INTERP,
    ST_FINAL,
    ST_FLUSH
  } lir_state_t;

endpackage

`default_nettype wire

@@ hdl/linear_interp_resampler_core.sv @@
`default_nettype none

// Linear-interpolation resampler. Each accepted frame (mono, or the floor average of left and
// right in stereo mode) yields zero or more output samples at the position spacing set by step
// (16 fraction bits), with last_of_run on the final sample of a frame and end_of_stream on the
// last sample of the buffer of sample_count frames. One frame at a time is processed: after
// the input transfer three bit-serial multipliers run (one multiplier bit per cycle) and the
// ST_MUL state then takes their products for the output limit and the interpolation. Results
// follow at one per cycle while the output side does not stall, the ST_FINAL and ST_FLUSH
// states close the frame, and ST_IDLE accepts the next.
// No clearing pass is needed after reset.
module linear_interp_resampler_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic        [lir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [lir_pkg::CFG_W-1:0]     cfg_data,
  // Input frames.
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [lir_pkg::SAMPLE_W-1:0]  left_sample,
  input  wire logic signed [lir_pkg::SAMPLE_W-1:0]  right_sample,
  // Output samples.
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [lir_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                      last_of_run,
  output logic                                      end_of_stream
);

  // Configuration registers.
  logic [lir_pkg::STEP_W-1:0]   step;
  logic                         stereo_mode;
  logic [lir_pkg::COUNT_W-1:0]  sample_count;

  // Stream state.
  lir_pkg::lir_state_t                 state, state_next;
  logic signed [lir_pkg::SAMPLE_W-1:0] prev_sample;
  logic signed [lir_pkg::SAMPLE_W-1:0] cur_sample;
  logic [lir_pkg::COUNT_W-1:0]         input_index;
  logic [lir_pkg::COUNT_W-1:0]         output_index;
  logic [lir_pkg::REL_W-1:0]           rel;
  logic                                rel_dead;
  logic                                first_frame;
  logic                                final_frame;
  logic [lir_pkg::STEP_W-1:0]          st;
  logic [lir_pkg::LIM_W-1:0]           lim;
  logic signed [lir_pkg::MUL_P_W-1:0]  dstep;
  logic signed [lir_pkg::MUL_P_W-1:0]  interp_prod;

  // Pending result, released once it is known whether it is the last of the frame.
  logic                                hold_valid;
  logic signed [lir_pkg::SAMPLE_W-1:0] hold_sample;
  logic                                hold_eos;

  // Input side arithmetic.
  logic signed [lir_pkg::SAMPLE_W:0]   pair_sum;
  logic signed [lir_pkg::SAMPLE_W-1:0] cur_in;
  logic signed [lir_pkg::DIFF_W-1:0]   diff_in;
  logic [lir_pkg::STEP_W-1:0]          st_in;
  logic [lir_pkg::COUNT_W:0]           idx_plus;

  // Multiplier connections.
  logic                                accept;
  logic                                mul_busy_lim, mul_busy_dst, mul_busy_int;
  logic signed [lir_pkg::MUL_P_W-1:0]  prod_lim, prod_dst, prod_int;
  logic signed [lir_pkg::MUL_A_W-1:0]  a_lim, a_diff;
  logic [lir_pkg::MUL_B_W-1:0]         b_rel;

  // Emission arithmetic.
  logic [lir_pkg::CAP_W-1:0]           cap;
  logic                                allowed;
  logic                                rel_below_one;
  logic [lir_pkg::COUNT_W-1:0]         idx_next;
  logic [lir_pkg::LIM_W-1:0]           lim_new;
  logic                                eos_new;
  logic signed [lir_pkg::SAMPLE_W-1:0] interp_val;
  logic                                move_ok;

  // Control strobes.
  logic                                mul_done;
  logic                                emit;
  logic signed [lir_pkg::SAMPLE_W-1:0] emit_val;
  logic                                out_load;
  logic                                out_last;
  logic                                interp_exit;
  logic                                item_done;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= lir_pkg::STEP_RST;
      stereo_mode  <= 1'b0;
      sample_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lir_pkg::REG_STEP:   step         <= cfg_data[lir_pkg::STEP_W-1:0];
        lir_pkg::REG_STEREO: stereo_mode  <= cfg_data[0];
        lir_pkg::REG_COUNT:  sample_count <= cfg_data[lir_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame reduction, difference and clamped step for the incoming transfer.
  always_comb begin
    pair_sum = {left_sample[lir_pkg::SAMPLE_W-1], left_sample}
             + {right_sample[lir_pkg::SAMPLE_W-1], right_sample};
    cur_in   = stereo_mode ? pair_sum[lir_pkg::SAMPLE_W:1] : left_sample;
    diff_in  = {cur_in[lir_pkg::SAMPLE_W-1], cur_in}
             - {prev_sample[lir_pkg::SAMPLE_W-1], prev_sample};
    st_in    = (step < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : step;
    idx_plus = {1'b0, output_index} + 1'b1;
    a_lim    = {1'b0, idx_plus};
    a_diff   = {diff_in[lir_pkg::DIFF_W-1], diff_in};
    b_rel    = {{(lir_pkg::MUL_B_W - lir_pkg::FRAC_BITS){1'b0}},
                rel[lir_pkg::FRAC_BITS-1:0]};
  end

  assign in_stall = (state != lir_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Limit product (output_index + 1) * step.
  lir_smul u_mul_lim (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (a_lim),
    .b     (st_in),
    .busy  (mul_busy_lim),
    .prod  (prod_lim)
  );

  // Per-output increment of the interpolation product, diff * step.
  lir_smul u_mul_dst (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (a_diff),
    .b     (st_in),
    .busy  (mul_busy_dst),
    .prod  (prod_dst)
  );

  // Interpolation product at the first output position, diff * frac.
  lir_smul u_mul_int (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (a_diff),
    .b     (b_rel),
    .busy  (mul_busy_int),
    .prod  (prod_int)
  );

  // Emission conditions and values for the next result.
  always_comb begin
    cap           = {sample_count, {lir_pkg::FRAC_BITS{1'b0}}};
    allowed       = (lim <= lir_pkg::LIM_W'(cap));
    rel_below_one = !rel_dead && (rel < lir_pkg::ONE_POS);
    idx_next      = output_index + 1'b1;
    lim_new       = (idx_next == '0) ? lir_pkg::LIM_W'(st) : lim + lir_pkg::LIM_W'(st);
    eos_new       = !(lim_new <= lir_pkg::LIM_W'(cap));
    interp_val    = prev_sample
                  + interp_prod[lir_pkg::FRAC_BITS+lir_pkg::SAMPLE_W-1:lir_pkg::FRAC_BITS];
    move_ok       = !out_valid || !out_stall;
    mul_done      = !mul_busy_lim && !mul_busy_dst && !mul_busy_int;
  end

  // Frame sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lir_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_val    = cur_sample;
    out_load    = 1'b0;
    out_last    = 1'b0;
    interp_exit = 1'b0;
    item_done   = 1'b0;
    case (state)
      lir_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lir_pkg::ST_MUL;
        end
      end
      lir_pkg::ST_MUL: begin
        if (mul_done) begin
          state_next = lir_pkg::ST_INTERP;
        end
      end
      lir_pkg::ST_INTERP: begin
        // Outputs between the previous and the current sample.
        if (first_frame) begin
          state_next = lir_pkg::ST_FINAL;
        end else if (rel_below_one && allowed) begin
          emit_val = interp_val;
          if (!hold_valid || move_ok) begin
            emit     = 1'b1;
            out_load = hold_valid;
          end
        end else begin
          interp_exit = 1'b1;
          state_next  = lir_pkg::ST_FINAL;
        end
      end
      lir_pkg::ST_FINAL: begin
        // On the final frame, outputs inside the last sample repeat it.
        if (final_frame && rel_below_one && allowed) begin
          if (!hold_valid || move_ok) begin
            emit     = 1'b1;
            out_load = hold_valid;
          end
        end else begin
          state_next = lir_pkg::ST_FLUSH;
        end
      end
      lir_pkg::ST_FLUSH: begin
        // Release the pending result marked as the last of this frame.
        if (!hold_valid) begin
          item_done  = 1'b1;
          state_next = lir_pkg::ST_IDLE;
        end else if (move_ok) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          item_done  = 1'b1;
          state_next = lir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lir_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state of the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_index  <= '0;
      output_index <= '0;
      rel          <= '0;
      rel_dead     <= 1'b0;
      prev_sample  <= '0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        input_index <= input_index + 1'b1;
      end
      if (emit) begin
        output_index <= idx_next;
        rel          <= rel + lir_pkg::REL_W'(st);
        hold_valid   <= 1'b1;
      end else if (interp_exit) begin
        // A position left short of the next sample can no longer be reached.
        if (rel_below_one || rel_dead) begin
          rel_dead <= 1'b1;
        end else begin
          rel <= rel - lir_pkg::ONE_POS;
        end
      end else if (item_done) begin
        hold_valid <= 1'b0;
      end
      if (item_done) begin
        prev_sample <= cur_sample;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-frame datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample  <= cur_in;
      st          <= st_in;
      first_frame <= (input_index == '0);
      final_frame <= ((input_index + 1'b1) == sample_count);
    end
    if (state == lir_pkg::ST_MUL && mul_done) begin
      lim         <= prod_lim[lir_pkg::LIM_W-1:0];
      dstep       <= prod_dst;
      interp_prod <= prod_int;
    end else if (emit) begin
      lim         <= lim_new;
      interp_prod <= interp_prod + dstep;
    end
    if (emit) begin
      hold_sample <= emit_val;
      hold_eos    <= eos_new;
    end
    if (out_load) begin
      out_sample    <= hold_sample;
      end_of_stream <= hold_eos;
      last_of_run   <= out_last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lir_smul.sv @@
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle, LSB first.
// The product bits shift out of the adder into the low half.
module lir_smul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [lir_pkg::MUL_A_W-1:0]  a,
  input  wire logic        [lir_pkg::MUL_B_W-1:0]  b,
  output logic                                     busy,
  output logic signed      [lir_pkg::MUL_P_W-1:0]  prod
);

  logic signed [lir_pkg::MUL_A_W-1:0]   mcand;
  logic        [lir_pkg::MUL_B_W-1:0]   mplier;
  logic signed [lir_pkg::MUL_A_W:0]     hi;
  logic        [lir_pkg::MUL_B_W-1:0]   lo;
  logic        [lir_pkg::MUL_CNT_W-1:0] cnt;
  logic signed [lir_pkg::MUL_A_W:0]     addend;
  logic signed [lir_pkg::MUL_A_W:0]     sum;

  // Partial product for the current multiplier bit.
  always_comb begin
    addend = mplier[0] ? {mcand[lir_pkg::MUL_A_W-1], mcand} : '0;
    sum    = hi + addend;
  end

  // Control: busy until every multiplier bit has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == lir_pkg::MUL_CNT_W'(lir_pkg::MUL_B_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: accumulate and shift right.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      hi     <= '0;
      lo     <= '0;
    end else if (busy) begin
      hi     <= sum >>> 1;
      lo     <= {sum[0], lo[lir_pkg::MUL_B_W-1:1]};
      mplier <= mplier >> 1;
    end
  end

  assign prod = {hi, lo};

endmodule

`default_nettype wire
